// ===== rtl/dnsax_pkg.sv =====
`timescale 1ns / 1ps
package dnsax_pkg;

   localparam int BUFFER_BYTES_DEF = 512;
   localparam int NAME_LIMIT_DEF   = 256;

   localparam int STATUS_W = 4;
   localparam int ADDR4_W  = 32;

   localparam logic [7:0] JUMP_LIMIT_RESET = 8'd16;

   localparam logic [STATUS_W-1:0] ST_FOUND      = 4'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT      = 4'd1;
   localparam logic [STATUS_W-1:0] ST_QNAME      = 4'd2;
   localparam logic [STATUS_W-1:0] ST_QEND       = 4'd3;
   localparam logic [STATUS_W-1:0] ST_ANAME      = 4'd4;
   localparam logic [STATUS_W-1:0] ST_ASHORT     = 4'd5;
   localparam logic [STATUS_W-1:0] ST_RDATA_LONG = 4'd6;
   localparam logic [STATUS_W-1:0] ST_NONE       = 4'd7;
   localparam logic [STATUS_W-1:0] ST_JUMPS      = 4'd8;

   localparam logic [7:0]  PTR_MASK  = 8'hC0;
   localparam logic [31:0] TYPE_CLASS_A_IN = 32'h0001_0001;
   localparam int HEADER_BYTES = 12;
   localparam int FIXED_BYTES  = 10;

endpackage

// ===== rtl/dnsax_ram.sv =====
`timescale 1ns / 1ps
module dnsax_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/dnsax_front.sv =====
`timescale 1ns / 1ps
module dnsax_front #(
   parameter int BUFFER_BYTES = dnsax_pkg::BUFFER_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   output logic                            wr_en,
   output logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
   output logic [7:0]                      wr_data,
   output logic                            job_valid,
   output logic [$clog2(BUFFER_BYTES):0]   job_plen,
   input  logic                            job_done
);
   import dnsax_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int PW = AW + 1;

   logic [PW-1:0] count_ff, count_in;
   logic [PW-1:0] plen_ff, plen_in;
   logic          job_ff, job_in;
   logic          accept;
   logic          room;

   assign accept = req_push && !job_ff;
   assign room   = count_ff < PW'(BUFFER_BYTES);

   always_comb begin
      count_in = count_ff;
      plen_in  = plen_ff;
      job_in   = job_ff;
      if (job_done) begin
         job_in = 1'b0;
      end
      if (accept) begin
         if (room) begin
            count_in = count_ff + PW'(1);
         end
         if (req_last_byte) begin
            plen_in  = room ? count_ff + PW'(1) : count_ff;
            job_in   = 1'b1;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         job_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         job_ff   <= job_in;
      end
      plen_ff <= plen_in;
   end

   assign req_full  = job_ff;
   assign wr_en     = accept && room;
   assign wr_addr   = count_ff[AW-1:0];
   assign wr_data   = req_data_byte;
   assign job_valid = job_ff;
   assign job_plen  = plen_ff;
endmodule

// ===== rtl/dnsax_back.sv =====
`timescale 1ns / 1ps
module dnsax_back #(
   parameter int BUFFER_BYTES = dnsax_pkg::BUFFER_BYTES_DEF,
   parameter int NAME_LIMIT   = dnsax_pkg::NAME_LIMIT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [7:0]                          csr_wdata,
   input  logic                                job_valid,
   input  logic [$clog2(BUFFER_BYTES):0]       job_plen,
   output logic                                job_done,
   output logic [$clog2(BUFFER_BYTES)-1:0]     rd_addr,
   input  logic [7:0]                          rd_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [dnsax_pkg::STATUS_W-1:0]      rsp_status,
   output logic [dnsax_pkg::ADDR4_W-1:0]       rsp_ipv4_address
);
   import dnsax_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int PW = AW + 1;
   localparam int EW = PW + 18;
   localparam int NW = $clog2(NAME_LIMIT) + 1;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_FETCH = 13'b0000000000010,
      S_CAPT  = 13'b0000000000100,
      S_HDR   = 13'b0000000001000,
      S_REC   = 13'b0000000010000,
      S_NAME  = 13'b0000000100000,
      S_LB    = 13'b0000001000000,
      S_PTR   = 13'b0000010000000,
      S_NEND  = 13'b0000100000000,
      S_AT    = 13'b0001000000000,
      S_AL    = 13'b0010000000000,
      S_AD    = 13'b0100000000000,
      S_RES   = 13'b1000000000000
   } state_type;

   state_type     state_ff, state_in, ret_ff, ret_in;
   logic [AW-1:0] ra_ff, ra_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [31:0]   sh_ff, sh_in;
   logic [15:0]   qd_ff, qd_in, an_ff, an_in, rc_ff, rc_in;
   logic          ques_ff, ques_in;
   logic [PW-1:0] pp_ff, pp_in, pos_ff, pos_in, resume_ff, resume_in;
   logic          jumped_ff, jumped_in, tc_ff, tc_in;
   logic [7:0]    jc_ff, jc_in, limit_ff;
   logic [NW-1:0] nct_ff, nct_in;
   logic [STATUS_W-1:0] st_ff, st_in, ost_ff, ost_in;
   logic [31:0]   ad_ff, ad_in, oad_ff, oad_in;
   logic          ov_ff, ov_in;

   logic [EW-1:0] plen_e, pos_e, lb_e, nct_e, lim_e, ppn_e, pp_e, end_e;
   logic [7:0]    lb;
   logic [PW-1:0] ppn;
   logic [13:0]   target;
   logic [15:0]   rdl;

   assign plen_e = EW'(job_plen);
   assign pos_e  = EW'(pos_ff);
   assign lb     = sh_ff[7:0];
   assign lb_e   = EW'(lb);
   assign nct_e  = EW'(nct_ff);
   assign lim_e  = EW'(NAME_LIMIT);
   assign ppn    = jumped_ff ? resume_ff : pos_ff;
   assign ppn_e  = EW'(ppn);
   assign pp_e   = EW'(pp_ff);
   assign target = {sh_ff[13:8], sh_ff[7:0]};
   assign rdl    = sh_ff[15:0];
   assign end_e  = pp_e + EW'(FIXED_BYTES) + EW'(rdl);

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      ra_in     = ra_ff;
      cnt_in    = cnt_ff;
      sh_in     = sh_ff;
      qd_in     = qd_ff;
      an_in     = an_ff;
      rc_in     = rc_ff;
      ques_in   = ques_ff;
      pp_in     = pp_ff;
      pos_in    = pos_ff;
      resume_in = resume_ff;
      jumped_in = jumped_ff;
      tc_in     = tc_ff;
      jc_in     = jc_ff;
      nct_in    = nct_ff;
      st_in     = st_ff;
      ad_in     = ad_ff;
      ost_in    = ost_ff;
      oad_in    = oad_ff;
      ov_in     = ov_ff;
      job_done  = 1'b0;
      if (ov_ff && rsp_pop) begin
         ov_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               ad_in = '0;
               if (plen_e < EW'(HEADER_BYTES)) begin
                  st_in    = ST_SHORT;
                  state_in = S_RES;
               end else begin
                  ra_in    = AW'(4);
                  cnt_in   = 3'd4;
                  ret_in   = S_HDR;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            state_in = S_CAPT;
         end
         S_CAPT: begin
            sh_in = {sh_ff[23:0], rd_data};
            if (cnt_ff == 3'd1) begin
               state_in = ret_ff;
            end else begin
               cnt_in   = cnt_ff - 3'd1;
               ra_in    = ra_ff + AW'(1);
               state_in = S_FETCH;
            end
         end
         S_HDR: begin
            qd_in    = sh_ff[31:16];
            an_in    = sh_ff[15:0];
            rc_in    = '0;
            ques_in  = 1'b1;
            pp_in    = PW'(HEADER_BYTES);
            state_in = S_REC;
         end
         S_REC: begin
            if (ques_ff && rc_ff == qd_ff) begin
               ques_in = 1'b0;
               rc_in   = '0;
            end else if (!ques_ff && rc_ff == an_ff) begin
               st_in    = ST_NONE;
               state_in = S_RES;
            end else begin
               pos_in    = pp_ff;
               nct_in    = '0;
               jc_in     = '0;
               jumped_in = 1'b0;
               state_in  = S_NAME;
            end
         end
         S_NAME: begin
            if (pos_e >= plen_e) begin
               state_in = S_NEND;
            end else begin
               ra_in    = pos_ff[AW-1:0];
               cnt_in   = 3'd1;
               ret_in   = S_LB;
               state_in = S_FETCH;
            end
         end
         S_LB: begin
            if (lb == 8'd0) begin
               pos_in   = pos_ff + PW'(1);
               state_in = S_NEND;
            end else if ((lb & PTR_MASK) == PTR_MASK) begin
               if (pos_e + EW'(1) >= plen_e) begin
                  st_in    = ques_ff ? ST_QNAME : ST_ANAME;
                  state_in = S_RES;
               end else begin
                  ra_in    = pos_ff[AW-1:0] + AW'(1);
                  cnt_in   = 3'd1;
                  ret_in   = S_PTR;
                  state_in = S_FETCH;
               end
            end else if (pos_e + EW'(1) + lb_e > plen_e ||
                         (nct_ff != '0 && nct_e + EW'(1) >= lim_e) ||
                         ((nct_ff != '0) ? nct_e + EW'(1) : nct_e) + lb_e >= lim_e) begin
               st_in    = ques_ff ? ST_QNAME : ST_ANAME;
               state_in = S_RES;
            end else begin
               nct_in   = NW'(((nct_ff != '0) ? nct_e + EW'(1) : nct_e) + lb_e);
               pos_in   = PW'(pos_e + EW'(1) + lb_e);
               state_in = S_NAME;
            end
         end
         S_PTR: begin
            if (EW'(target) >= plen_e) begin
               st_in    = ques_ff ? ST_QNAME : ST_ANAME;
               state_in = S_RES;
            end else if (jc_ff >= limit_ff) begin
               st_in    = ST_JUMPS;
               state_in = S_RES;
            end else begin
               jc_in = jc_ff + 8'd1;
               if (!jumped_ff) begin
                  resume_in = pos_ff + PW'(2);
               end
               jumped_in = 1'b1;
               pos_in    = PW'(target);
               state_in  = S_NAME;
            end
         end
         S_NEND: begin
            if (ques_ff) begin
               if (ppn_e + EW'(4) >= plen_e) begin
                  st_in    = ST_QEND;
                  state_in = S_RES;
               end else begin
                  pp_in    = ppn + PW'(4);
                  rc_in    = rc_ff + 16'd1;
                  state_in = S_REC;
               end
            end else if (ppn_e + EW'(FIXED_BYTES) > plen_e) begin
               st_in    = ST_ASHORT;
               state_in = S_RES;
            end else begin
               pp_in    = ppn;
               ra_in    = ppn[AW-1:0];
               cnt_in   = 3'd4;
               ret_in   = S_AT;
               state_in = S_FETCH;
            end
         end
         S_AT: begin
            tc_in    = sh_ff == TYPE_CLASS_A_IN;
            ra_in    = pp_ff[AW-1:0] + AW'(8);
            cnt_in   = 3'd2;
            ret_in   = S_AL;
            state_in = S_FETCH;
         end
         S_AL: begin
            if (end_e > plen_e) begin
               st_in    = ST_RDATA_LONG;
               state_in = S_RES;
            end else if (tc_ff && rdl == 16'd4) begin
               ra_in    = pp_ff[AW-1:0] + AW'(FIXED_BYTES);
               cnt_in   = 3'd4;
               ret_in   = S_AD;
               state_in = S_FETCH;
            end else begin
               pp_in    = PW'(end_e);
               rc_in    = rc_ff + 16'd1;
               state_in = S_REC;
            end
         end
         S_AD: begin
            st_in    = ST_FOUND;
            ad_in    = sh_ff;
            state_in = S_RES;
         end
         S_RES: begin
            if (!ov_ff) begin
               ov_in    = 1'b1;
               ost_in   = st_ff;
               oad_in   = ad_ff;
               job_done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
         limit_ff <= JUMP_LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         if (csr_write) begin
            limit_ff <= csr_wdata;
         end
      end
      ret_ff    <= ret_in;
      ra_ff     <= ra_in;
      cnt_ff    <= cnt_in;
      sh_ff     <= sh_in;
      qd_ff     <= qd_in;
      an_ff     <= an_in;
      rc_ff     <= rc_in;
      ques_ff   <= ques_in;
      pp_ff     <= pp_in;
      pos_ff    <= pos_in;
      resume_ff <= resume_in;
      jumped_ff <= jumped_in;
      tc_ff     <= tc_in;
      jc_ff     <= jc_in;
      nct_ff    <= nct_in;
      st_ff     <= st_in;
      ad_ff     <= ad_in;
      ost_ff    <= ost_in;
      oad_ff    <= oad_in;
   end

   assign rd_addr          = ra_ff;
   assign rsp_empty        = !ov_ff;
   assign rsp_status       = ost_ff;
   assign rsp_ipv4_address = oad_ff;
endmodule

// ===== rtl/dns_a_record_extractor_top.sv =====
`timescale 1ns / 1ps
// Extracts the first IPv4 address record from a DNS response.
// Input queue: response bytes are pushed with req_push, one per cycle while
// req_full is low, with req_last_byte marking the final byte. At most
// BUFFER_BYTES bytes are kept. After the last byte, req_full stays high while
// the stored response is parsed and until its result has been moved into the
// result register. Result queue: one item per response, with rsp_status and
// rsp_ipv4_address, is shown while rsp_empty is low and taken with rsp_pop.
// The parser reads the packet store through its one registered read port,
// one byte per fetch and capture state pair. It reads the header counts,
// walks each name label by label and follows compression jumps, steps over
// each question's fields, and reads each answer's fixed fields and, for the
// matching record, its address; a response is parsed once fully loaded.
// If the receiver stalls, the finished item waits in the result register.
// The next response is then loaded and parsed, but its item waits in the
// parser with req_full high until the first item is popped.
// The csr port sets the jump limit; the user must write it only while the
// block idles, which the block does not enforce. Reset, synchronous and
// active high, empties both queues and sets the jump limit to 16; the packet store needs no clearing.
module dns_a_record_extractor_top #(
   parameter int BUFFER_BYTES = dnsax_pkg::BUFFER_BYTES_DEF,
   parameter int NAME_LIMIT   = dnsax_pkg::NAME_LIMIT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_last_byte,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [dnsax_pkg::STATUS_W-1:0] rsp_status,
   output logic [dnsax_pkg::ADDR4_W-1:0]  rsp_ipv4_address,
   input  logic                           csr_write,
   input  logic [7:0]                     csr_wdata
);
   import dnsax_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;
   logic          job_valid, job_done;
   logic [AW:0]   job_plen;

   dnsax_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_data_byte(req_data_byte), .req_last_byte(req_last_byte),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .job_valid(job_valid), .job_plen(job_plen), .job_done(job_done)
   );

   dnsax_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   dnsax_back #(.BUFFER_BYTES(BUFFER_BYTES), .NAME_LIMIT(NAME_LIMIT)) u_back (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .job_valid(job_valid), .job_plen(job_plen), .job_done(job_done),
      .rd_addr(rd_addr), .rd_data(rd_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_status(rsp_status), .rsp_ipv4_address(rsp_ipv4_address)
   );

`ifndef SYNTHESIS
   a_no_write_while_parsing: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> !wr_en)
      else $error("packet store written while a response is parsed");
   a_done_only_with_job: assert property (@(posedge clock) disable iff (reset)
      job_done |-> job_valid && rsp_empty)
      else $error("result finished without a pending response");
   a_addr_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_FOUND) |-> rsp_ipv4_address == '0)
      else $error("address not zero on an error item");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_status <= ST_JUMPS)
      else $error("status code out of range");
`endif
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import dnsax_pkg::*;

   localparam int STORE_BYTES = 512;
   localparam int NAME_MAX    = 256;
   localparam int CYCLE_LIMIT = 1000000;

   typedef logic [7:0] byte_q_type[$];
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } resp_byte_type;
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR4_W-1:0]  ipv4_address;
   } lookup_type;
   typedef enum int {WALK_OK, WALK_BAD, WALK_JUMPS} walk_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic [7:0] req_data_byte = 8'd0;
   logic req_last_byte = 1'b0;
   logic rsp_pop = 1'b0;
   logic csr_write = 1'b0;
   logic [7:0] csr_wdata = 8'd0;
   logic req_full, rsp_empty;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR4_W-1:0] rsp_ipv4_address;

   resp_byte_type byte_feed[$];
   lookup_type lookups_due[$];
   logic [7:0] resp_store[STORE_BYTES];
   int resp_len = 0;
   logic [7:0] jump_lim = JUMP_LIMIT_RESET;
   int errors = 0;
   int cycles = 0;
   int tx_gap = 0;
   int rx_gap = 0;
   int rx_hold_left = 0;
   bit no_idle = 0;

   dns_a_record_extractor_top i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_data_byte(req_data_byte), .req_last_byte(req_last_byte),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_status(rsp_status), .rsp_ipv4_address(rsp_ipv4_address),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int rd8(int at);
      return at < STORE_BYTES ? int'(resp_store[at]) : 0;
   endfunction

   function automatic int rd16(int at);
      return (rd8(at) << 8) | rd8(at + 1);
   endfunction

   function automatic walk_type walk_name(inout int pos, input int plen);
      int p, resume, total, jumps, lb, tgt;
      bit jumped;
      p = pos;
      resume = pos;
      total = 0;
      jumps = 0;
      jumped = 0;
      while (p < plen) begin
         lb = rd8(p);
         if (lb == 0) begin
            p++;
            break;
         end
         if ((lb & int'(PTR_MASK)) == int'(PTR_MASK)) begin
            if (p + 1 >= plen) return WALK_BAD;
            tgt = ((lb & 'h3F) << 8) | rd8(p + 1);
            if (tgt >= plen) return WALK_BAD;
            if (jumps >= int'(jump_lim)) return WALK_JUMPS;
            jumps++;
            if (!jumped) resume = p + 2;
            jumped = 1;
            p = tgt;
            continue;
         end
         p++;
         if (p + lb > plen) return WALK_BAD;
         if (total != 0) begin
            if (total + 1 < NAME_MAX) total++;
            else return WALK_BAD;
         end
         if (total + lb >= NAME_MAX) return WALK_BAD;
         total += lb;
         p += lb;
      end
      pos = jumped ? resume : p;
      return WALK_OK;
   endfunction

   function automatic lookup_type parse_response(int plen);
      lookup_type r;
      int qd, an, pos, rtype, rclass, rdlen;
      walk_type w;
      r.ipv4_address = '0;
      if (plen < HEADER_BYTES) begin
         r.status = ST_SHORT;
         return r;
      end
      qd = rd16(4);
      an = rd16(6);
      pos = HEADER_BYTES;
      for (int i = 0; i < qd; i++) begin
         w = walk_name(pos, plen);
         if (w == WALK_JUMPS) begin
            r.status = ST_JUMPS;
            return r;
         end
         if (w != WALK_OK) begin
            r.status = ST_QNAME;
            return r;
         end
         pos += 4;
         if (pos >= plen) begin
            r.status = ST_QEND;
            return r;
         end
      end
      for (int i = 0; i < an; i++) begin
         w = walk_name(pos, plen);
         if (w == WALK_JUMPS) begin
            r.status = ST_JUMPS;
            return r;
         end
         if (w != WALK_OK) begin
            r.status = ST_ANAME;
            return r;
         end
         if (pos + FIXED_BYTES > plen) begin
            r.status = ST_ASHORT;
            return r;
         end
         rtype = rd16(pos);
         rclass = rd16(pos + 2);
         rdlen = rd16(pos + 8);
         pos += FIXED_BYTES;
         if (pos + rdlen > plen) begin
            r.status = ST_RDATA_LONG;
            return r;
         end
         if (rtype == 1 && rclass == 1 && rdlen == 4) begin
            r.status = ST_FOUND;
            r.ipv4_address = {resp_store[pos], resp_store[pos+1], resp_store[pos+2],
                              resp_store[pos+3]};
            return r;
         end
         pos += rdlen;
      end
      r.status = ST_NONE;
      return r;
   endfunction

   task automatic report(input string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      lookup_type want;
      if (!reset && req_push && !req_full) begin
         if (resp_len < STORE_BYTES) resp_store[resp_len] = req_data_byte;
         if (resp_len < STORE_BYTES) resp_len++;
         if (req_last_byte) begin
            lookups_due.push_back(parse_response(resp_len));
            resp_len = 0;
         end
         void'(byte_feed.pop_front());
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         if (lookups_due.size() == 0) begin
            report("result with none expected");
         end else begin
            want = lookups_due.pop_front();
            if (rsp_status !== want.status)
               report($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_ipv4_address !== want.ipv4_address)
               report($sformatf("address %h, expected %h", rsp_ipv4_address,
                                want.ipv4_address));
         end
      end
   end

   always @(negedge clock) begin
      if (reset || byte_feed.size() == 0) begin
         req_push <= 1'b0;
      end else if (tx_gap > 0) begin
         tx_gap--;
         req_push <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 11) == 0) begin
         tx_gap = $urandom_range(1, 15) - 1;
         req_push <= 1'b0;
      end else begin
         req_push <= 1'b1;
         req_data_byte <= byte_feed[0].data_byte;
         req_last_byte <= byte_feed[0].last_byte;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_pop <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_pop <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
         rx_gap = $urandom_range(1, 15) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic send(input byte_q_type p);
      resp_byte_type b;
      foreach (p[i]) begin
         b.data_byte = p[i];
         b.last_byte = (i == p.size() - 1);
         byte_feed.push_back(b);
      end
   endtask

   task automatic wait_idle();
      while (byte_feed.size() != 0 || lookups_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_jump_limit(input logic [7:0] v);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      jump_lim = v;
   endtask

   task automatic add_header(inout byte_q_type p, input int qd, input int an);
      p.push_back(8'($urandom_range(0, 255)));
      p.push_back(8'($urandom_range(0, 255)));
      p.push_back(8'h81);
      p.push_back(8'h80);
      p.push_back(8'(qd >> 8));
      p.push_back(8'(qd & 'hFF));
      p.push_back(8'(an >> 8));
      p.push_back(8'(an & 'hFF));
      repeat (4) p.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'h00);
   endtask

   task automatic add_name(inout byte_q_type p);
      int n, len;
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
         len = $urandom_range(1, 8);
         p.push_back(8'(len));
         repeat (len) p.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end
      if (p.size() > 20 && $urandom_range(0, 3) == 0) begin
         p.push_back(8'hC0);
         p.push_back(8'h0C);
      end else begin
         p.push_back(8'h00);
      end
   endtask

   task automatic add_answer(inout byte_q_type p, input bit plain_a, input int rdlen);
      p.push_back(8'h00);
      p.push_back(plain_a ? 8'h01 : 8'($urandom_range(0, 255)));
      p.push_back(8'h00);
      p.push_back(plain_a ? 8'h01 : 8'($urandom_range(0, 3)));
      repeat (4) p.push_back(8'($urandom_range(0, 255)));
      p.push_back(8'(rdlen >> 8));
      p.push_back(8'(rdlen & 'hFF));
      repeat (rdlen) p.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic make_response(output byte_q_type p);
      int qd, an, off, cut;
      p = {};
      qd = $urandom_range(0, 2);
      an = $urandom_range(0, 3);
      add_header(p, qd, an);
      if ($urandom_range(0, 19) == 0) begin
         p[4] = 8'($urandom_range(0, 255));
         p[6] = 8'($urandom_range(0, 255));
      end
      for (int i = 0; i < qd; i++) begin
         add_name(p);
         p.push_back(8'h00); p.push_back(8'h01); p.push_back(8'h00); p.push_back(8'h01);
      end
      for (int i = 0; i < an; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               off = p.size();
               p.push_back(8'(8'hC0 | (off >> 8)));
               p.push_back(8'(off & 'hFF));
            end
            1: begin
               p.push_back(8'(8'hC0 | $urandom_range(0, 63)));
               p.push_back(8'($urandom_range(0, 255)));
            end
            2, 3: add_name(p);
            default: begin
               if (qd > 0) begin
                  p.push_back(8'hC0);
                  p.push_back(8'h0C);
               end else begin
                  p.push_back(8'h00);
               end
            end
         endcase
         add_answer(p, $urandom_range(0, 4) != 0,
                    $urandom_range(0, 3) != 0 ? 4 : $urandom_range(0, 7));
      end
      case ($urandom_range(0, 7))
         0: begin
            cut = $urandom_range(1, p.size());
            while (p.size() > cut) void'(p.pop_back());
         end
         1: p[$urandom_range(0, p.size() - 1)] = 8'($urandom_range(0, 255));
         2: begin
            p = {};
            repeat ($urandom_range(1, 40)) p.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
   endtask

   task automatic random_phase(input int min_bytes, input int min_responses);
      byte_q_type p;
      int nbytes, nresp;
      nbytes = 0;
      nresp = 0;
      while (nbytes < min_bytes || nresp < min_responses) begin
         make_response(p);
         send(p);
         nbytes += p.size();
         nresp++;
      end
   endtask

   task automatic directed();
      byte_q_type p;
      int off;
      p = {};
      p.push_back(8'h00);
      send(p);
      p = {};
      repeat (11) p.push_back(8'hFF);
      send(p);
      p = {}; add_header(p, 0, 0); send(p);
      p = {}; add_header(p, 1, 1); add_name(p);
      p.push_back(8'h00); p.push_back(8'h01); p.push_back(8'h00); p.push_back(8'h01);
      p.push_back(8'hC0); p.push_back(8'h0C);
      add_answer(p, 1, 0);
      p[p.size()-1] = 8'h04;
      p.push_back(8'hFF); p.push_back(8'h00); p.push_back(8'hFF); p.push_back(8'h00);
      send(p);
      p = {}; add_header(p, 1, 0); p.push_back(8'h01); p.push_back(8'h61);
      p.push_back(8'h00); p.push_back(8'h00); p.push_back(8'h01); p.push_back(8'h00);
      p.push_back(8'h01); send(p);
      p = {}; add_header(p, 1, 0); p.push_back(8'h09); p.push_back(8'h61); send(p);
      p = {}; add_header(p, 0, 1); p.push_back(8'h00); p.push_back(8'h00); send(p);
      p = {}; add_header(p, 0, 1); p.push_back(8'h00); add_answer(p, 1, 0);
      p[p.size()-1] = 8'h08; p.push_back(8'h01); send(p);
      p = {}; add_header(p, 0, 1); off = p.size();
      p.push_back(8'hC0); p.push_back(8'(off)); add_answer(p, 1, 4); send(p);
      p = {}; add_header(p, 1, 0); p.push_back(8'h3F);
      repeat (63) p.push_back(8'h62);
      p.push_back(8'hC0); p.push_back(8'h0C); repeat (4) p.push_back(8'h01); send(p);
      p = {}; add_header(p, 0, 1); p.push_back(8'hC1); p.push_back(8'h00);
      add_answer(p, 1, 4); send(p);
      p = {}; add_header(p, 0, 1); p.push_back(8'hC0); send(p);
      p = {}; add_header(p, 1, 1); p.push_back(8'h41); repeat (65) p.push_back(8'h63);
      p.push_back(8'h00); repeat (4) p.push_back(8'h01);
      p.push_back(8'hC0); p.push_back(8'h0C); add_answer(p, 1, 4); send(p);
      p = {}; add_header(p, 1, 0); p.push_back(8'hBF); p.push_back(8'h64); send(p);
      p = {}; add_header(p, 0, 1); p.push_back(8'h02); p.push_back(8'h65);
      p.push_back(8'h65); send(p);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      directed();
      wait_idle();
      set_jump_limit(8'd1);
      random_phase(60, 2);
      wait_idle();
      set_jump_limit(8'd255);
      rx_hold_left = 800;
      random_phase(100, 3);
      wait_idle();
      set_jump_limit(8'($urandom_range(1, 254)));
      random_phase(60, 2);
      wait_idle();
      no_idle = 1;
      set_jump_limit(JUMP_LIMIT_RESET);
      random_phase(60, 2);
      wait_idle();
      repeat (200) @(posedge clock);
      if (errors == 0 && lookups_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== dns_a_record_extractor_top.f =====
rtl/dnsax_pkg.sv
rtl/dnsax_ram.sv
rtl/dnsax_front.sv
rtl/dnsax_back.sv
rtl/dns_a_record_extractor_top.sv
bench/tb_top.sv
